// ===== sv/suc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package suc_pkg;

  // Field widths fixed by the interface
  localparam int VALUE_W = 32;
  localparam int COUNT_W = 7;

  // Transaction state as it moves down the cell chain
  typedef struct packed {
    logic                      valid;
    logic                      last;
    logic                      found;
    logic                      placed;
    logic signed [VALUE_W-1:0] value;
  } token_t;

endpackage

`default_nettype wire

// ===== sv/suc_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

// One storage slot of the distinct-value chain. A passing transaction is
// compared against the slot, claims it if it is the first free one, counts it
// if occupied, and clears it when the transaction closes the set.
module suc_cell #(
  parameter int CW = 7
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire suc_pkg::token_t tok_in,
  input  wire logic [CW-1:0]   cnt_in,
  output suc_pkg::token_t      tok_out,
  output logic [CW-1:0]        cnt_out
);

  logic                               vld_r;
  logic                               vld_nxt;
  logic signed [suc_pkg::VALUE_W-1:0] val_r;
  logic signed [suc_pkg::VALUE_W-1:0] val_nxt;
  suc_pkg::token_t                    tok_r;
  suc_pkg::token_t                    tok_nxt;
  logic [CW-1:0]                      cnt_r;
  logic [CW-1:0]                      cnt_nxt;
  logic                               hit;
  logic                               take;
  logic                               occupied;

  // Compare and claim
  assign hit      = tok_in.valid && vld_r && (val_r == tok_in.value);
  assign take     = tok_in.valid && !vld_r && !tok_in.found && !tok_in.placed;
  assign occupied = vld_r || take;

  always_comb begin
    tok_nxt        = tok_in;
    tok_nxt.found  = tok_in.found || hit;
    tok_nxt.placed = tok_in.placed || take;
    cnt_nxt        = cnt_in + {{(CW-1){1'b0}}, occupied};
    vld_nxt        = vld_r;
    val_nxt        = val_r;
    if (take) begin
      vld_nxt = 1'b1;
      val_nxt = tok_in.value;
    end
    // end of set empties the slot after this transaction has used it
    if (tok_in.valid && tok_in.last) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= 1'b0;
      tok_r.valid <= 1'b0;
    end else begin
      vld_r       <= vld_nxt;
      tok_r.valid <= tok_nxt.valid;
    end
    val_r        <= val_nxt;
    tok_r.last   <= tok_nxt.last;
    tok_r.found  <= tok_nxt.found;
    tok_r.placed <= tok_nxt.placed;
    tok_r.value  <= tok_nxt.value;
    cnt_r        <= cnt_nxt;
  end

  assign tok_out = tok_r;
  assign cnt_out = cnt_r;

endmodule

`default_nettype wire

// ===== sv/set_union_distinct_collector_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Distinct-value collector: keeps each value once, in order of first arrival,
// in a chain of CAPACITY cells. A transaction is taken when start is high and
// busy is low; busy is high during reset and for the first cycle after it.
// Each transaction walks the chain one cell per cycle. Its result is on the
// out_ ports, marked by out_strobe for one cycle, once it has passed the
// registers of all CAPACITY cells. A new transaction can be taken every
// cycle; results come out in order, one per transaction, and cannot be
// stalled. end_of_set empties the store after that transaction's
// result; the reported count is before the clear. A new value seen while all
// CAPACITY cells are full is dropped and flagged by out_overflow.
module set_union_distinct_collector_core #(
  parameter int CAPACITY = 64
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               start,
  output logic                                    busy,
  input  wire logic signed [suc_pkg::VALUE_W-1:0] in_value,
  input  wire logic                               in_end_of_set,
  output logic                                    out_strobe,
  output logic                                    out_is_new,
  output logic signed [suc_pkg::VALUE_W-1:0]      out_stored_value,
  output logic [suc_pkg::COUNT_W-1:0]             out_distinct_count,
  output logic                                    out_overflow
);

  localparam int CW = $clog2(CAPACITY + 1);

  suc_pkg::token_t             tok  [0:CAPACITY];
  logic [CW-1:0]               cnt  [0:CAPACITY];
  logic                        busy_r;
  logic [CW+suc_pkg::COUNT_W-1:0] cnt_ext;

  // Busy for one cycle after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  assign busy = busy_r;

  // Chain entry
  always_comb begin
    tok[0].valid  = start && !busy_r;
    tok[0].last   = in_end_of_set;
    tok[0].found  = 1'b0;
    tok[0].placed = 1'b0;
    tok[0].value  = in_value;
  end
  assign cnt[0] = '0;

  // Cell chain
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    suc_cell #(
      .CW(CW)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .tok_in (tok[i]),
      .cnt_in (cnt[i]),
      .tok_out(tok[i+1]),
      .cnt_out(cnt[i+1])
    );
  end

  // Result from the last cell's register
  assign cnt_ext            = {{suc_pkg::COUNT_W{1'b0}}, cnt[CAPACITY]};
  assign out_strobe         = tok[CAPACITY].valid;
  assign out_is_new         = tok[CAPACITY].placed;
  assign out_overflow       = !tok[CAPACITY].found && !tok[CAPACITY].placed;
  assign out_stored_value   = tok[CAPACITY].value;
  assign out_distinct_count = cnt_ext[suc_pkg::COUNT_W-1:0];

endmodule

`default_nettype wire

// ===== sv/suc_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module suc_checker #(
  parameter int CAPACITY = 64
) (
  input wire logic                               clk,
  input wire logic                               rst_n,
  input wire logic                               start,
  input wire logic                               busy,
  input wire logic signed [suc_pkg::VALUE_W-1:0] in_value,
  input wire logic                               in_end_of_set,
  input wire logic                               out_strobe,
  input wire logic                               out_is_new,
  input wire logic signed [suc_pkg::VALUE_W-1:0] out_stored_value,
  input wire logic [suc_pkg::COUNT_W-1:0]        out_distinct_count,
  input wire logic                               out_overflow
);

  localparam int CW = $clog2(CAPACITY + 2);
  localparam logic [31:0] CAP_W = 32'(CAPACITY);

  logic [CW-1:0] age_r;
  logic          warm;

  // Cycles since reset, saturating once the chain has been flushed
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      age_r <= '0;
    end else if (32'(age_r) < CAP_W + 32'd1) begin
      age_r <= age_r + 1'b1;
    end
  end

  assign warm = (32'(age_r) > CAP_W);

  // One result per accepted transaction, in order, and none where none was accepted
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    warm |-> (out_strobe == $past(start && !busy, CAPACITY)))
    else $error("result strobe does not match accepted transaction");

  // Result echoes the accepted value
  a_echo: assert property (@(posedge clk) disable iff (!rst_n)
    (warm && out_strobe) |-> (out_stored_value == $past(in_value, CAPACITY)))
    else $error("echoed value mismatch");

  // New and overflow are exclusive
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !(out_is_new && out_overflow))
    else $error("is_new and overflow both set");

  // Overflow only with a full store
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_overflow) |->
      (out_distinct_count == CAP_W[suc_pkg::COUNT_W-1:0]))
    else $error("overflow with store not full");

  // An appended value leaves a nonempty store
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_is_new && (CAPACITY < 128)) |-> (out_distinct_count != '0))
    else $error("new value reported with zero count");

endmodule

bind set_union_distinct_collector_core suc_checker #(
  .CAPACITY(CAPACITY)
) u_suc_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .start             (start),
  .busy              (busy),
  .in_value          (in_value),
  .in_end_of_set     (in_end_of_set),
  .out_strobe        (out_strobe),
  .out_is_new        (out_is_new),
  .out_stored_value  (out_stored_value),
  .out_distinct_count(out_distinct_count),
  .out_overflow      (out_overflow)
);

`default_nettype wire
